>>> rtl/otmc_pkg.sv
// ----------------------------------------------------------------------------
// Oven timer mode controller package
// Command codes, field widths and constants shared by the controller files.
// ----------------------------------------------------------------------------
package otmc_pkg;

	localparam int unsigned OpWidth   = 4;
	localparam int unsigned SecsWidth = 16;

	// Command codes carried in the operation field.
	typedef enum logic [OpWidth-1:0] {
		OP_TICK     = 4'd0,
		OP_ADD10    = 4'd1,
		OP_ADD60    = 4'd2,
		OP_ADD1800  = 4'd3,
		OP_START    = 4'd4,
		OP_PAUSE    = 4'd5,
		OP_STOP     = 4'd6,
		OP_MICRO    = 4'd7,
		OP_GRILL    = 4'd8,
		OP_SET_TIME = 4'd9
	} op_t;

	// Cooking modes.
	localparam logic MODE_MICRO = 1'b0;
	localparam logic MODE_GRILL = 1'b1;

	localparam logic [SecsWidth-1:0] SECS_RESET = 16'd100;
	localparam logic [SecsWidth-1:0] SECS_MAX   = 16'hFFFF;
	localparam logic [SecsWidth-1:0] SECS_10    = 16'd10;
	localparam logic [SecsWidth-1:0] SECS_60    = 16'd60;
	localparam logic [SecsWidth-1:0] SECS_1800  = 16'd1800;

endpackage

>>> rtl/otmc_if.sv
// ----------------------------------------------------------------------------
// Oven timer mode controller channels
// Valid/ready channels for commands and for the results they produce.
// ----------------------------------------------------------------------------
interface otmc_cmd_if
	import otmc_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [OpWidth-1:0]   operation;
	logic [SecsWidth-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface otmc_res_if
	import otmc_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic                 running;
	logic [SecsWidth-1:0] seconds_left;
	logic                 done_res;
	logic                 rejected;

	modport source (output valid, output mode, output running, output seconds_left,
		output done_res, output rejected, input ready);
	modport sink   (input valid, input mode, input running, input seconds_left,
		input done_res, input rejected, output ready);
endinterface

>>> rtl/oven_timer_mode_controller.sv
// ----------------------------------------------------------------------------
// Oven timer mode controller
// Cook timer with microwave/grill mode, run flag and a saturating seconds count.
// ----------------------------------------------------------------------------
// Each command transaction on cmd produces exactly one result transaction on
// res, reporting the mode, run flag and seconds left after the command, plus a
// done flag for the tick that ends a countdown and a rejected flag for a
// command that is not allowed in the current state. The block accepts one
// command per clock cycle, except while a full input register waits behind a
// stalled result register. A command sits in the input register, where a
// short stretch of logic works out the next state from the current state
// registers, until it moves into the result register as the state updates;
// the result is offered on res from there. The result register and the input
// register together let a new command be taken while an earlier result still
// waits for res.ready; throughput is then set only by how often the result
// side accepts. After reset the block is in microwave mode, idle, with 100
// seconds loaded.
module oven_timer_mode_controller
	import otmc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	otmc_cmd_if.sink        cmd,
	otmc_res_if.source      res
);

	// Input stage: one command waiting for evaluation.
	logic                 valid_s1;
	op_t                  op_s1;
	logic [SecsWidth-1:0] value_s1;

	// Controller state.
	logic                 mode_q;
	logic                 running_q;
	logic [SecsWidth-1:0] secs_q;

	// Result stage.
	logic                 valid_s2;
	logic                 mode_s2;
	logic                 running_s2;
	logic [SecsWidth-1:0] secs_s2;
	logic                 done_s2;
	logic                 rej_s2;

	// Next-state logic outputs.
	logic                 mode_d;
	logic                 running_d;
	logic [SecsWidth-1:0] secs_d;
	logic                 done_d;
	logic                 rej_d;
	logic [SecsWidth:0]   add_sum;
	logic [SecsWidth-1:0] add_amount;
	logic [SecsWidth-1:0] secs_dec;

	logic s2_load;
	logic s1_advance;

	// The result register may be loaded when empty or when its result leaves now.
	assign s2_load    = !valid_s2 || res.ready;
	assign s1_advance = valid_s1 && s2_load;
	assign cmd.ready  = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1    <= op_t'(cmd.operation);
			value_s1 <= cmd.value;
		end
	end

	// Amount for the add commands, and the saturating sum.
	always_comb begin
		case (op_s1)
			OP_ADD10:   add_amount = SECS_10;
			OP_ADD60:   add_amount = SECS_60;
			OP_ADD1800: add_amount = SECS_1800;
			default:    add_amount = '0;
		endcase
	end

	assign add_sum  = {1'b0, secs_q} + {1'b0, add_amount};
	assign secs_dec = (secs_q != '0) ? secs_q - SecsWidth'(1) : secs_q;

	// Command evaluation against the current state.
	always_comb begin
		mode_d    = mode_q;
		running_d = running_q;
		secs_d    = secs_q;
		done_d    = 1'b0;
		rej_d     = 1'b0;
		case (op_s1)
			OP_TICK: begin
				// A tick while idle is just time passing: no change, not rejected.
				if (running_q) begin
					secs_d = secs_dec;
					if (secs_dec == '0) begin
						done_d    = 1'b1;
						running_d = 1'b0;
					end
				end
			end
			OP_ADD10, OP_ADD60, OP_ADD1800: begin
				secs_d = add_sum[SecsWidth] ? SECS_MAX : add_sum[SecsWidth-1:0];
			end
			OP_START: begin
				if (running_q) rej_d = 1'b1;
				else running_d = 1'b1;
			end
			OP_PAUSE: begin
				if (running_q) running_d = 1'b0;
				else rej_d = 1'b1;
			end
			OP_STOP: begin
				running_d = 1'b0;
				secs_d    = '0;
			end
			OP_MICRO: begin
				if (running_q) rej_d = 1'b1;
				else mode_d = MODE_MICRO;
			end
			OP_GRILL: begin
				if (running_q) rej_d = 1'b1;
				else mode_d = MODE_GRILL;
			end
			OP_SET_TIME: begin
				if (running_q) rej_d = 1'b1;
				else secs_d = value_s1;
			end
			default: begin
				// Undefined codes change nothing and are refused.
				rej_d = 1'b1;
			end
		endcase
	end

	// State commits as the command moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_MICRO;
			running_q <= 1'b0;
			secs_q    <= SECS_RESET;
		end else if (s1_advance) begin
			mode_q    <= mode_d;
			running_q <= running_d;
			secs_q    <= secs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			mode_s2    <= mode_d;
			running_s2 <= running_d;
			secs_s2    <= secs_d;
			done_s2    <= done_d;
			rej_s2     <= rej_d;
		end
	end

	assign res.valid        = valid_s2;
	assign res.mode         = mode_s2;
	assign res.running      = running_s2;
	assign res.seconds_left = secs_s2;
	assign res.done_res     = done_s2;
	assign res.rejected     = rej_s2;

endmodule

>>> rtl/otmc_checker.sv
// ----------------------------------------------------------------------------
// Oven timer mode controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module otmc_checker
	import otmc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 res_mode,
	input logic                 res_running,
	input logic [SecsWidth-1:0] res_seconds_left,
	input logic                 res_done_res,
	input logic                 res_rejected
);

	// A stalled result keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_mode) && $stable(res_running)
			&& $stable(res_seconds_left) && $stable(res_done_res) && $stable(res_rejected))
		else $error("result changed while stalled");

	// The tick that ends a countdown leaves the timer idle at zero.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done_res |-> !res_running && res_seconds_left == '0)
		else $error("done reported with timer not idle at zero");

	// A refused command never finishes a countdown.
	a_rej_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_rejected |-> !res_done_res)
		else $error("rejected and done both set");

	// A refused command leaves state as the previous result reported it.
	a_rej_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready ##1 res_valid && res_rejected && $past(res_ready) |->
			res_mode == $past(res_mode) && res_running == $past(res_running)
			&& res_seconds_left == $past(res_seconds_left))
		else $error("rejected command changed state");

endmodule

bind oven_timer_mode_controller otmc_checker u_otmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_mode         (res.mode),
	.res_running      (res.running),
	.res_seconds_left (res.seconds_left),
	.res_done_res     (res.done_res),
	.res_rejected     (res.rejected)
);

>>> dv/otmc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oven timer result checker
// Watches the command and result channels, keeps its own copy of the cook
// timer state and compares every result with the status it predicts.
// ----------------------------------------------------------------------------
module otmc_result_checker
	import otmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	otmc_cmd_if         cmd,
	otmc_res_if         res,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic                 mode;
		logic                 running;
		logic [SecsWidth-1:0] seconds_left;
		logic                 done_res;
		logic                 rejected;
	} cook_status_t;

	logic                 cook_mode;
	logic                 cooking;
	logic [SecsWidth-1:0] secs_left;
	cook_status_t         expected_status_q[$];

	function automatic logic [SecsWidth-1:0] add_saturated(input logic [SecsWidth-1:0] base,
		input logic [SecsWidth-1:0] amount);
		logic [SecsWidth:0] sum;
		sum = {1'b0, base} + {1'b0, amount};
		return sum[SecsWidth] ? SECS_MAX : sum[SecsWidth-1:0];
	endfunction

	// Applies one command to the timer copy and returns the status it reports.
	task automatic apply_command(input logic [OpWidth-1:0] op,
		input logic [SecsWidth-1:0] secs, output cook_status_t status);
		logic done;
		logic rej;
		done = 1'b0;
		rej  = 1'b0;
		case (op_t'(op))
			OP_TICK: begin
				if (cooking) begin
					if (secs_left != '0)
						secs_left = secs_left - SecsWidth'(1);
					if (secs_left == '0) begin
						done    = 1'b1;
						cooking = 1'b0;
					end
				end
			end
			OP_ADD10:   secs_left = add_saturated(secs_left, SECS_10);
			OP_ADD60:   secs_left = add_saturated(secs_left, SECS_60);
			OP_ADD1800: secs_left = add_saturated(secs_left, SECS_1800);
			OP_START: begin
				if (cooking) rej = 1'b1;
				else cooking = 1'b1;
			end
			OP_PAUSE: begin
				if (cooking) cooking = 1'b0;
				else rej = 1'b1;
			end
			OP_STOP: begin
				cooking   = 1'b0;
				secs_left = '0;
			end
			OP_MICRO: begin
				if (cooking) rej = 1'b1;
				else cook_mode = MODE_MICRO;
			end
			OP_GRILL: begin
				if (cooking) rej = 1'b1;
				else cook_mode = MODE_GRILL;
			end
			OP_SET_TIME: begin
				if (cooking) rej = 1'b1;
				else secs_left = secs;
			end
			default: rej = 1'b1;
		endcase
		status = '{mode: cook_mode, running: cooking, seconds_left: secs_left,
			done_res: done, rejected: rej};
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("[%0t] result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cook_status_t want;
		cook_status_t got;
		if (!arst_n) begin
			cook_mode  = MODE_MICRO;
			cooking    = 1'b0;
			secs_left  = SECS_RESET;
			fail_count = 0;
			expected_status_q.delete();
		end else begin
			// A result taken now belongs to an earlier command, so it is checked
			// before a command taken at the same edge is queued.
			if (res.valid && res.ready) begin
				got = '{mode: res.mode, running: res.running, seconds_left: res.seconds_left,
					done_res: res.done_res, rejected: res.rejected};
				if (expected_status_q.size() == 0) begin
					$display("[%0t] result transaction with no command waiting", $time);
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					if (got.mode !== want.mode)
						report_mismatch("mode", got.mode, want.mode);
					if (got.running !== want.running)
						report_mismatch("running", got.running, want.running);
					if (got.seconds_left !== want.seconds_left)
						report_mismatch("seconds_left", got.seconds_left, want.seconds_left);
					if (got.done_res !== want.done_res)
						report_mismatch("done_res", got.done_res, want.done_res);
					if (got.rejected !== want.rejected)
						report_mismatch("rejected", got.rejected, want.rejected);
				end
			end
			if (cmd.valid && cmd.ready) begin
				apply_command(cmd.operation, cmd.value, want);
				expected_status_q.push_back(want);
			end
		end
		pending = expected_status_q.size();
	end

endmodule

>>> dv/oven_timer_mode_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oven timer mode controller testbench
// Drives command transactions into the cook timer, takes its results with
// random back-pressure and lets a checker compare every result it produces.
// ----------------------------------------------------------------------------
module oven_timer_mode_controller_tb;
	import otmc_pkg::*;

	typedef logic [OpWidth-1:0]   op_code_t;
	typedef logic [SecsWidth-1:0] secs_t;

	// Limit on the length of the whole run.
	localparam int unsigned CycleLimit   = 400_000;
	localparam int unsigned RandomItems  = 1500;
	localparam int unsigned MaxGap       = 18;
	// The receiver stops taking results for this long once, so that the
	// block fills its two internal registers and has to drop cmd.ready.
	localparam int unsigned HoldOffCycles = 120;
	localparam int unsigned HoldOffAt     = 300;
	// Extra wait after the last predicted result, so that a stray one is caught.
	localparam int unsigned DrainCycles   = 8;

	logic        clk;
	logic        arst_n;
	int unsigned chk_fails;
	int unsigned chk_pending;
	int unsigned cycle_count;
	logic        hold_off;
	logic        cmd_burst;
	logic        res_burst;

	otmc_cmd_if cmd_ch();
	otmc_res_if res_ch();

	oven_timer_mode_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	otmc_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A run that hangs, for example on a ready that never comes back, ends here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offers one command transaction. It is called at a falling edge and returns
	// at the falling edge after the transaction was taken. With no gap drawn,
	// valid simply stays high into the next transaction.
	task automatic send_command(input op_code_t op, input secs_t secs);
		int unsigned gap;
		gap = (cmd_burst || hold_off) ? 0 : $urandom_range(0, MaxGap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.value     <= secs;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: a random stall before each result, with stretches of no
	// stall at all, and one long hold-off partway through the run.
	initial begin
		int unsigned taken;
		int unsigned gap;
		logic        held;
		res_ch.ready = 1'b0;
		hold_off     = 1'b0;
		res_burst    = 1'b0;
		taken        = 0;
		held         = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (taken % 64 == 0)
				res_burst = ($urandom_range(0, 3) == 0);
			if (!held && taken == HoldOffAt) begin
				held          = 1'b1;
				hold_off      = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				hold_off      = 1'b0;
			end
			gap = res_burst ? 0 : $urandom_range(0, MaxGap);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// Command side and verdict.
	initial begin
		int unsigned counted;
		int unsigned steps;
		int unsigned item_no;
		op_code_t    op;
		secs_t       secs;

		cmd_ch.valid     = 1'b0;
		cmd_ch.operation = OP_TICK;
		cmd_ch.value     = '0;
		cmd_burst        = 1'b0;
		arst_n           = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A tick while idle changes nothing and is not rejected.
		send_command(OP_TICK, SECS_MAX);
		send_command(OP_ADD10, '0);
		send_command(OP_ADD60, '0);
		send_command(OP_ADD1800, '0);
		// Adds saturate at the top of the counter.
		send_command(OP_SET_TIME, SECS_MAX);
		send_command(OP_ADD10, '0);
		send_command(OP_ADD1800, '0);
		send_command(OP_GRILL, '0);
		// Starting with zero seconds is allowed; the next tick ends the cook.
		send_command(OP_SET_TIME, '0);
		send_command(OP_START, '0);
		send_command(OP_TICK, '0);
		// Pause while idle is rejected.
		send_command(OP_PAUSE, '0);
		send_command(OP_SET_TIME, secs_t'(2));
		send_command(OP_START, '0);
		// While cooking, start, mode selection and set time are all rejected.
		send_command(OP_START, '0);
		send_command(OP_GRILL, '0);
		send_command(OP_MICRO, '0);
		send_command(OP_SET_TIME, secs_t'(16'h5555));
		send_command(OP_ADD60, '0);
		send_command(OP_TICK, '0);
		send_command(OP_PAUSE, '0);
		send_command(OP_MICRO, '0);
		send_command(OP_START, '0);
		send_command(OP_STOP, '0);
		// Codes past the last defined command are rejected without effect.
		for (int c = int'(OP_SET_TIME) + 1; c < 2 ** OpWidth; c++)
			send_command(op_code_t'(c), secs_t'(16'hAAAA));

		// Random part. Most of it is whole cook cycles with short times so
		// that countdowns run out often; the rest is single random commands,
		// undefined codes included. Single ticks and undefined codes are not counted.
		counted = 0;
		item_no = 0;
		while (counted < RandomItems) begin
			if (item_no % 64 == 0)
				cmd_burst = ($urandom_range(0, 3) == 0);
			item_no++;
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1) == 1) begin
					send_command($urandom_range(0, 1) ? OP_GRILL : OP_MICRO, secs_t'($urandom));
					counted++;
				end
				secs = ($urandom_range(0, 7) == 0) ? secs_t'($urandom)
					: secs_t'($urandom_range(0, 12));
				send_command(OP_SET_TIME, secs);
				send_command(OP_START, secs_t'($urandom));
				steps = $urandom_range(1, MaxGap);
				// Now and then a user command lands in the middle of the countdown.
				repeat (steps) begin
					if ($urandom_range(0, 9) == 0)
						send_command(op_code_t'($urandom_range(int'(OP_ADD10),
							int'(OP_SET_TIME))), secs_t'($urandom));
					else
						send_command(OP_TICK, secs_t'($urandom));
				end
				counted += steps + 2;
			end else begin
				op = op_code_t'($urandom);
				send_command(op, secs_t'($urandom));
				if (op != OP_TICK && op <= OP_SET_TIME)
					counted++;
			end
		end
		cmd_ch.valid <= 1'b0;

		// Wait for every predicted result, then a few more cycles so that a
		// stray extra result would still be caught.
		while (chk_pending != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (chk_pending != 0)
			$display("%0d result transactions never arrived", chk_pending);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/otmc_pkg.sv
rtl/otmc_if.sv
rtl/oven_timer_mode_controller.sv
rtl/otmc_checker.sv
dv/otmc_result_checker.sv
dv/oven_timer_mode_controller_tb.sv
